// ----- sv/sorted_key_value_table_defines.svh -----
// Assertion macros shared by the sorted key/value table RTL.
`ifndef SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKVT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKVT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/skvt_pkg.sv -----
// Shared types, request codes and defaults of the sorted key/value table.
package skvt_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FUNC_BITS  = 3;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int CFG_BITS   = 9;

    localparam logic [CFG_BITS-1:0] MAX_ENTRIES_RST = 9'd256;

    localparam logic [FUNC_BITS-1:0] FN_INSERT     = 3'd0;
    localparam logic [FUNC_BITS-1:0] FN_UPDATE     = 3'd1;
    localparam logic [FUNC_BITS-1:0] FN_INS_UPD    = 3'd2;
    localparam logic [FUNC_BITS-1:0] FN_ERASE      = 3'd3;
    localparam logic [FUNC_BITS-1:0] FN_CONTAINS   = 3'd4;
    localparam logic [FUNC_BITS-1:0] FN_GET_KEY    = 3'd5;
    localparam logic [FUNC_BITS-1:0] FN_GET_INDEX  = 3'd6;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
        logic [CFG_BITS-1:0]  index;
    } req_t;

    typedef struct packed {
        logic                ok;
        logic [KEY_W-1:0]    found_key;
        logic [VALUE_W-1:0]  found_value;
        logic [CFG_BITS-1:0] count;
        logic                is_empty;
    } rsp_t;

endpackage

// ----- sv/skvt_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module skvt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/sorted_key_value_table.sv -----
// Top level of the sorted key/value table: request sequencer around one entry RAM.
`include "sorted_key_value_table_defines.svh"
//
// Usage
//   A request beat (req: func, key, value, index) is taken on a rising edge with
//   start high and busy low. busy stays high until the result is issued.
//   Each request yields exactly one result beat: done is high for one cycle and
//   rsp (ok, found_key, found_value, count, is_empty) is valid in that cycle.
//   The receiver cannot stall; grab rsp whenever done is high.
//   The user writes the capacity register (cfg_we/cfg_data) only while no request
//   is in flight; the block does not enforce this. Resets to 256, clipped to DEPTH.
// Timing
//   Entries sit in one RAM, sorted by key, one read and one write per cycle.
//   get_by_index: the entry is read, then ST_IDXRD issues done. Unused code or index out
//   of range: done follows in the cycle after accept.
//   Key operations scan linearly from rank 0 until the first key not below the
//   request key or the last rank, then decide in ST_ACT. Insert and erase
//   then move each entry above the slot by one rank, one entry per cycle.
//   Scan and shift each cover count ranks at most.
// Reset
//   rst_n clears the count and the sequencer; RAM contents are left as they are
//   since only ranks below the count are ever read.
module sorted_key_value_table
    import skvt_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  req_t                req,
    output logic                done,
    output rsp_t                rsp,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int MW = KEY_BITS + VALUE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_SHUP,
        ST_PUT,
        ST_SHDN,
        ST_IDXRD
    } state_t;

    state_t                 state_reg, state_next;
    logic [FUNC_BITS-1:0]   func_reg, func_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic                   hit_reg, hit_next;
    logic [VALUE_BITS-1:0]  hval_reg, hval_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CFG_BITS-1:0]    max_reg;
    logic                   done_reg, done_next;
    rsp_t                   rsp_reg, rsp_next;

    // RAM ports
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [MW-1:0]          rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [MW-1:0]          wr_data;

    logic [KEY_BITS-1:0]    rd_key;
    logic [VALUE_BITS-1:0]  rd_val;
    logic [KEY_BITS-1:0]    in_key;
    logic [LW-1:0]          limit;
    logic                   cap_full;

    // response staging
    logic                   r_fire;
    logic                   r_ok;
    logic [KEY_W-1:0]       r_fkey;
    logic [VALUE_W-1:0]     r_fval;

    assign rd_key   = rd_data[MW-1:VALUE_BITS];
    assign rd_val   = rd_data[VALUE_BITS-1:0];
    assign in_key   = KEY_BITS'(req.key);
    assign limit    = (LW'(max_reg) < LW'(DEPTH)) ? LW'(max_reg) : LW'(DEPTH);
    assign cap_full = LW'(cnt_reg) >= limit;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    skvt_ram #(
        .DEPTH (DEPTH),
        .WIDTH (MW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Sequencer. Reads and writes never hit the same address in one cycle:
    // shifts write rank j while reading j-2 (up) or j+2 (down), and every
    // write of a request lands before the next request issues its first read.
    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        hit_next   = hit_reg;
        hval_next  = hval_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        r_fire     = 1'b0;
        r_ok       = 1'b0;
        r_fkey     = KEY_W'(key_reg);
        r_fval     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next = req.func;
                    key_next  = in_key;
                    val_next  = VALUE_BITS'(req.value);
                    r_fkey    = KEY_W'(in_key);
                    unique case (req.func) inside
                        FN_GET_INDEX:
                        begin
                            if (LW'(req.index) < LW'(cnt_reg))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(req.index);
                                state_next = ST_IDXRD;
                            end
                            else
                            begin
                                r_fire = 1'b1;
                            end
                        end
                        FN_INSERT, FN_UPDATE, FN_INS_UPD, FN_ERASE, FN_CONTAINS,
                        FN_GET_KEY:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pos_next   = '0;
                                hit_next   = 1'b0;
                                state_next = ST_ACT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                ptr_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            r_fire = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // stop at the first key not below the request key
                if (rd_key >= key_reg)
                begin
                    pos_next   = ptr_reg;
                    hit_next   = (rd_key == key_reg);
                    hval_next  = rd_val;
                    state_next = ST_ACT;
                end
                else if (CW'(ptr_reg + 1'b1) == cnt_reg)
                begin
                    pos_next   = cnt_reg;
                    hit_next   = 1'b0;
                    state_next = ST_ACT;
                end
                else
                begin
                    ptr_next = CW'(ptr_reg + 1'b1);
                    rd_en    = 1'b1;
                    rd_addr  = AW'(ptr_reg + 1'b1);
                end
            end

            ST_ACT:
            begin
                case (func_reg) inside
                    FN_INSERT, FN_INS_UPD:
                    begin
                        if (func_reg == FN_INS_UPD && hit_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(pos_reg);
                            wr_data = {key_reg, val_reg};
                            r_ok    = 1'b1;
                            r_fire  = 1'b1;
                        end
                        else if (hit_reg || cap_full)
                        begin
                            r_fire = 1'b1;
                        end
                        else if (pos_reg == cnt_reg)
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = AW'(pos_reg);
                            wr_data  = {key_reg, val_reg};
                            cnt_next = CW'(cnt_reg + 1'b1);
                            r_ok     = 1'b1;
                            r_fire   = 1'b1;
                        end
                        else
                        begin
                            // open the slot: move ranks pos..count-1 up by one
                            ptr_next   = cnt_reg;
                            rd_en      = 1'b1;
                            rd_addr    = AW'(cnt_reg - 1'b1);
                            state_next = ST_SHUP;
                        end
                    end
                    FN_UPDATE:
                    begin
                        if (hit_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(pos_reg);
                            wr_data = {key_reg, val_reg};
                        end
                        r_ok   = hit_reg;
                        r_fire = 1'b1;
                    end
                    FN_ERASE:
                    begin
                        if (!hit_reg)
                        begin
                            r_fire = 1'b1;
                        end
                        else if (CW'(pos_reg + 1'b1) == cnt_reg)
                        begin
                            cnt_next = CW'(cnt_reg - 1'b1);
                            r_ok     = 1'b1;
                            r_fire   = 1'b1;
                        end
                        else
                        begin
                            // close the gap: move ranks above pos down by one
                            ptr_next   = pos_reg;
                            rd_en      = 1'b1;
                            rd_addr    = AW'(pos_reg + 1'b1);
                            state_next = ST_SHDN;
                        end
                    end
                    FN_CONTAINS:
                    begin
                        r_ok   = hit_reg;
                        r_fire = 1'b1;
                    end
                    FN_GET_KEY:
                    begin
                        r_ok   = hit_reg;
                        r_fval = hit_reg ? VALUE_W'(hval_reg) : '0;
                        r_fire = 1'b1;
                    end
                    default:
                    begin
                        r_fire = 1'b1;
                    end
                endcase
            end

            ST_SHUP:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(ptr_reg);
                wr_data = rd_data;
                if (CW'(ptr_reg - 1'b1) == pos_reg)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    ptr_next = CW'(ptr_reg - 1'b1);
                    rd_en    = 1'b1;
                    rd_addr  = AW'(ptr_reg - 2'd2);
                end
            end

            ST_PUT:
            begin
                wr_en    = 1'b1;
                wr_addr  = AW'(pos_reg);
                wr_data  = {key_reg, val_reg};
                cnt_next = CW'(cnt_reg + 1'b1);
                r_ok     = 1'b1;
                r_fire   = 1'b1;
            end

            ST_SHDN:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(ptr_reg);
                wr_data = rd_data;
                if (CW'(ptr_reg + 2'd2) == cnt_reg)
                begin
                    cnt_next = CW'(cnt_reg - 1'b1);
                    r_ok     = 1'b1;
                    r_fire   = 1'b1;
                end
                else
                begin
                    ptr_next = CW'(ptr_reg + 1'b1);
                    rd_en    = 1'b1;
                    rd_addr  = AW'(ptr_reg + 2'd2);
                end
            end

            ST_IDXRD:
            begin
                r_ok   = 1'b1;
                r_fkey = KEY_W'(rd_key);
                r_fval = VALUE_W'(rd_val);
                r_fire = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // issue the result beat and drop back to idle
        if (r_fire)
        begin
            state_next           = ST_IDLE;
            done_next            = 1'b1;
            rsp_next.ok          = r_ok;
            rsp_next.found_key   = r_fkey;
            rsp_next.found_value = r_fval;
            rsp_next.count       = CFG_BITS'(cnt_next);
            rsp_next.is_empty    = (cnt_next == '0);
        end
    end

    // control state, capacity register and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            max_reg   <= MAX_ENTRIES_RST;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    // request payload, scan results and result payload
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        ptr_reg  <= ptr_next;
        pos_reg  <= pos_next;
        hit_reg  <= hit_next;
        hval_reg <= hval_next;
        rsp_reg  <= rsp_next;
    end

    // every accepted request is either in flight or answered on the next cycle
    `SKVT_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done,
        "accepted request neither in flight nor answered")
    // a result beat always leaves the sequencer idle
    `SKVT_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy, "result issued while busy")
    // the shift schedule keeps read and write apart in the same cycle
    `SKVT_ASSERT_IMP(a_ram_ports_apart, clk, rst_n, wr_en && rd_en, wr_addr != rd_addr,
        "RAM read and write collide on one address")
    // no RAM write without a request in flight
    `SKVT_ASSERT_IMP(a_write_busy, clk, rst_n, wr_en, state_reg != ST_IDLE,
        "RAM written while idle")

endmodule
